@@ src/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared assertion macros for the numeric page encoder.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Check that cons holds in the cycle after ante.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ src/pocsag_pkg.sv @@
// ----------------------------------------------------------------------------
// pocsag_pkg
// Types, constants and codeword helpers for the numeric page encoder.
// ----------------------------------------------------------------------------
package pocsag_pkg;

  // Input item kinds
  localparam logic [1:0] FUNC_START = 2'd0;
  localparam logic [1:0] FUNC_CHAR  = 2'd1;
  localparam logic [1:0] FUNC_END   = 2'd2;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_SYNC      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IDLE      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PREAMBLE  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PRE_COUNT = 2'd3;

  // Configuration reset values
  localparam logic [31:0] SYNC_RST      = 32'h7CD2_15D8;
  localparam logic [31:0] IDLE_RST      = 32'h7A89_C197;
  localparam logic [31:0] PREAMBLE_RST  = 32'hAAAA_AAAA;
  localparam logic [4:0]  PRE_COUNT_RST = 5'd20;
  localparam logic [4:0]  MAX_PRE       = 5'd20;

  // BCH(31,21) generator, left aligned
  localparam logic [31:0] BCH_GEN = 32'hED20_0000;

  // Character codes
  localparam logic [7:0] CH_A       = 8'h41;
  localparam logic [7:0] CH_B       = 8'h42;
  localparam logic [7:0] CH_C       = 8'h43;
  localparam logic [7:0] CH_D       = 8'h44;
  localparam logic [7:0] CH_E       = 8'h45;
  localparam logic [7:0] CH_F       = 8'h46;
  localparam logic [7:0] CH_U       = 8'h55;
  localparam logic [7:0] CH_NL      = 8'h0A;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_DASH    = 8'h2D;
  localparam logic [7:0] CH_LBRACK  = 8'h5B;
  localparam logic [7:0] CH_RBRACK  = 8'h5D;
  localparam logic [3:0] SPACE_CODE = 4'hC;

  // Queue depths
  localparam int CMD_DEPTH_DEF = 4;
  localparam int OUT_DEPTH_DEF = 2;

  typedef struct packed {
    logic [1:0]  func;
    logic [20:0] address;
    logic [1:0]  function_bits;
    logic [7:0]  character;
  } in_item_t;

  typedef struct packed {
    logic [31:0] codeword;
    logic        last_of_run;
  } out_item_t;

  typedef struct packed {
    logic                 valid;
    logic [CFG_IDX_W-1:0] index;
    logic [31:0]          data;
  } cfg_wr_t;

  // Work handed from the front to the back
  typedef enum logic [1:0] {
    CMD_START,
    CMD_MSG,
    CMD_IDLE
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [20:0] data;        // upper 21 bits of the address or message codeword
    logic [2:0]  frame;
    logic        sync_first;
    logic        idle_after;
  } cmd_t;

  typedef enum logic [2:0] {
    BK_LOAD,
    BK_PRE,
    BK_SYNC,
    BK_FILL,
    BK_WORD,
    BK_TAIL
  } back_state_t;

  // Map a character to its numeric code
  function automatic logic [3:0] char_code(input logic [7:0] ch);
    logic [3:0] code;
    case (ch)
      CH_A, CH_NL:          code = 4'hA;
      CH_B, CH_U:           code = 4'hB;
      CH_C, CH_SPACE:       code = 4'hC;
      CH_D, CH_DASH:        code = 4'hD;
      CH_E, CH_LBRACK:      code = 4'hE;
      CH_F, CH_RBRACK:      code = 4'hF;
      default:              code = ch[3:0];
    endcase
    return code;
  endfunction

  function automatic logic [3:0] rev4(input logic [3:0] c);
    return {c[0], c[1], c[2], c[3]};
  endfunction

  // Check bits contributed by a single set bit b of the codeword
  function automatic logic [9:0] bch_col(input int b);
    logic [31:0] r;
    r = 32'h1 << b;
    for (int j = 0; j < 21; j++) begin
      if (r[31]) r = r ^ BCH_GEN;
      r = r << 1;
    end
    return r[31:22];
  endfunction

  // Append BCH check bits and even parity; linear, so one XOR tree
  function automatic logic [31:0] with_check(input logic [20:0] d);
    logic [9:0]  chk;
    logic [31:0] w;
    chk = '0;
    for (int i = 0; i < 21; i++) begin
      if (d[i]) chk = chk ^ bch_col(i + 11);
    end
    w = {d, chk, 1'b0};
    w[0] = ^w[31:1];
    return w;
  endfunction

endpackage

@@ src/pocsag_fifo.sv @@
// ----------------------------------------------------------------------------
// pocsag_fifo
// Small register-based queue used for the encoder's command and output queues.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pocsag_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CNT_W'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  // Advance pointers with wrap at the depth
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Store the pushed entry
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  `ASSERT_IMPLIES(a_fifo_cnt_bound, clk, rst_n, 1'b1, cnt_r <= CNT_W'(DEPTH))

endmodule

@@ src/pocsag_front.sv @@
// ----------------------------------------------------------------------------
// pocsag_front
// Accepts input items, packs numeric codes and issues codeword commands.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pocsag_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_push,
  input  pocsag_pkg::in_item_t in_item,
  output logic                 in_full,
  output logic                 cmd_push,
  output pocsag_pkg::cmd_t     cmd_wdata,
  input  logic                 cmd_full
);

  import pocsag_pkg::*;

  logic [19:0] acc_r, acc_nxt;
  logic [2:0]  cnt_r, cnt_nxt;
  logic [3:0]  slot_r, slot_nxt;
  logic        open_r, open_nxt;
  logic        accept;
  logic [19:0] acc_char;
  logic [19:0] acc_pad;
  logic [3:0]  pad;

  assign in_full = cmd_full;
  assign accept  = in_push && !cmd_full;
  assign pad     = rev4(SPACE_CODE);
  assign acc_char = {acc_r[15:0], rev4(char_code(in_item.character))};

  // Fill the rest of a partial word with space codes
  always_comb begin
    case (cnt_r)
      3'd1:    acc_pad = {acc_r[3:0], pad, pad, pad, pad};
      3'd2:    acc_pad = {acc_r[7:0], pad, pad, pad};
      3'd3:    acc_pad = {acc_r[11:0], pad, pad};
      3'd4:    acc_pad = {acc_r[15:0], pad};
      default: acc_pad = acc_r;
    endcase
  end

  // Classify the item and build the command
  always_comb begin
    acc_nxt   = acc_r;
    cnt_nxt   = cnt_r;
    slot_nxt  = slot_r;
    open_nxt  = open_r;
    cmd_push  = 1'b0;
    cmd_wdata = '{kind: CMD_IDLE, data: '0, frame: '0, sync_first: 1'b0,
                  idle_after: 1'b0};
    if (accept) begin
      case (in_item.func)
        FUNC_START: begin
          cmd_push         = 1'b1;
          cmd_wdata.kind   = CMD_START;
          cmd_wdata.data   = {1'b0, in_item.address[20:3], in_item.function_bits};
          cmd_wdata.frame  = in_item.address[2:0];
          slot_nxt         = {in_item.address[2:0], 1'b1};
          acc_nxt          = '0;
          cnt_nxt          = '0;
          open_nxt         = 1'b1;
        end
        FUNC_CHAR: begin
          if (open_r) begin
            if (cnt_r == 3'd4) begin
              cmd_push             = 1'b1;
              cmd_wdata.kind       = CMD_MSG;
              cmd_wdata.data       = {1'b1, acc_char};
              cmd_wdata.sync_first = (slot_r == '0);
              slot_nxt             = slot_r + 1'b1;
              acc_nxt              = '0;
              cnt_nxt              = '0;
            end else begin
              acc_nxt = acc_char;
              cnt_nxt = cnt_r + 1'b1;
            end
          end
        end
        FUNC_END: begin
          if (open_r) begin
            cmd_push = 1'b1;
            if (cnt_r != '0) begin
              cmd_wdata.kind       = CMD_MSG;
              cmd_wdata.data       = {1'b1, acc_pad};
              cmd_wdata.sync_first = (slot_r == '0);
              cmd_wdata.idle_after = 1'b1;
              slot_nxt             = slot_r + 1'b1;
            end else begin
              cmd_wdata.kind = CMD_IDLE;
            end
            acc_nxt  = '0;
            cnt_nxt  = '0;
            open_nxt = 1'b0;
          end
        end
        default: begin
          // drop unused item kind
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r  <= '0;
      cnt_r  <= '0;
      slot_r <= '0;
      open_r <= 1'b0;
    end else begin
      acc_r  <= acc_nxt;
      cnt_r  <= cnt_nxt;
      slot_r <= slot_nxt;
      open_r <= open_nxt;
    end
  end

  `ASSERT_IMPLIES(a_front_cnt_bound, clk, rst_n, 1'b1, cnt_r <= 3'd4)

endmodule

@@ src/pocsag_back.sv @@
// ----------------------------------------------------------------------------
// pocsag_back
// Expands commands into codewords and holds the configuration registers.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pocsag_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  pocsag_pkg::cfg_wr_t   cfg,
  input  pocsag_pkg::cmd_t      cmd_rdata,
  input  logic                  cmd_empty,
  output logic                  cmd_pop,
  output logic                  out_push,
  output pocsag_pkg::out_item_t out_wdata,
  input  logic                  out_full
);

  import pocsag_pkg::*;

  back_state_t state_r, state_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  cmd_t        cur_r;
  logic [31:0] sync_r, idle_r, pre_word_r;
  logic [4:0]  pre_cnt_r;
  logic [4:0]  pc_sat;
  logic [4:0]  fill_end;
  logic        go;

  assign pc_sat   = (pre_cnt_r > MAX_PRE) ? MAX_PRE : pre_cnt_r;
  assign fill_end = {1'b0, cur_r.frame, 1'b0} - 5'd1;
  assign go       = !out_full;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_r     <= SYNC_RST;
      idle_r     <= IDLE_RST;
      pre_word_r <= PREAMBLE_RST;
      pre_cnt_r  <= PRE_COUNT_RST;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_SYNC:      sync_r     <= cfg.data;
        REG_IDLE:      idle_r     <= cfg.data;
        REG_PREAMBLE:  pre_word_r <= cfg.data;
        REG_PRE_COUNT: pre_cnt_r  <= cfg.data[4:0];
        default: ;
      endcase
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      BK_LOAD: begin
        if (!cmd_empty) begin
          cnt_nxt = '0;
          case (cmd_rdata.kind)
            CMD_START: state_nxt = (pc_sat != '0) ? BK_PRE : BK_SYNC;
            CMD_MSG:   state_nxt = cmd_rdata.sync_first ? BK_SYNC : BK_WORD;
            default:   state_nxt = BK_TAIL;
          endcase
        end
      end
      BK_PRE: begin
        if (go) begin
          if (cnt_r == pc_sat - 5'd1) begin
            state_nxt = BK_SYNC;
            cnt_nxt   = '0;
          end else begin
            cnt_nxt = cnt_r + 5'd1;
          end
        end
      end
      BK_SYNC: begin
        if (go) begin
          if (cur_r.kind == CMD_START && cur_r.frame != '0) begin
            state_nxt = BK_FILL;
          end else begin
            state_nxt = BK_WORD;
          end
          cnt_nxt = '0;
        end
      end
      BK_FILL: begin
        if (go) begin
          if (cnt_r == fill_end) begin
            state_nxt = BK_WORD;
            cnt_nxt   = '0;
          end else begin
            cnt_nxt = cnt_r + 5'd1;
          end
        end
      end
      BK_WORD: begin
        if (go) begin
          state_nxt = (cur_r.kind == CMD_MSG && cur_r.idle_after) ? BK_TAIL : BK_LOAD;
        end
      end
      BK_TAIL: begin
        if (go) state_nxt = BK_LOAD;
      end
      default: state_nxt = BK_LOAD;
    endcase
  end

  // Outputs
  always_comb begin
    cmd_pop   = 1'b0;
    out_push  = 1'b0;
    out_wdata = '{codeword: '0, last_of_run: 1'b0};
    case (state_r)
      BK_LOAD: cmd_pop = !cmd_empty;
      BK_PRE: begin
        out_push           = go;
        out_wdata.codeword = pre_word_r;
      end
      BK_SYNC: begin
        out_push           = go;
        out_wdata.codeword = sync_r;
      end
      BK_FILL: begin
        out_push           = go;
        out_wdata.codeword = idle_r;
      end
      BK_WORD: begin
        out_push              = go;
        out_wdata.codeword    = with_check(cur_r.data);
        out_wdata.last_of_run = !(cur_r.kind == CMD_MSG && cur_r.idle_after);
      end
      BK_TAIL: begin
        out_push              = go;
        out_wdata.codeword    = idle_r;
        out_wdata.last_of_run = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_LOAD;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // Hold the command being expanded
  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      cur_r <= cmd_rdata;
    end
  end

  `ASSERT_IMPLIES(a_back_fill_frame, clk, rst_n, state_r == BK_FILL, cur_r.frame != '0)
  `ASSERT_IMPLIES(a_back_tail_kind, clk, rst_n, state_r == BK_TAIL, cur_r.kind != CMD_START)

endmodule

@@ src/pocsag_numeric_page_encoder.sv @@
// ----------------------------------------------------------------------------
// pocsag_numeric_page_encoder
// Numeric pager codeword generator: start, character and end items in,
// 32-bit codewords out.
// ----------------------------------------------------------------------------
//  channel  ports                               handshake
//  input    in_push, in_full, in_item           push and not full
//  result   out_pop, out_empty, out_item        pop and not empty
//  config   cfg_valid, cfg_ready, cfg_index,    valid and ready
//           cfg_data
//
// A character item that does not finish a word is only packed in the front.
// Each back command passes a load state, then its codewords: a start gives
// min(preamble_count, 20) + 2 + 2 * (address mod 8) words, a message
// word one or two, an end one to three. The back's single codeword path sets
// the rate. The command queue lets the front keep accepting while the back
// works; a full output queue stalls the back, and the input only once the
// command queue has filled. Reset is synchronous and needs no clearing pass.
// ----------------------------------------------------------------------------
module pocsag_numeric_page_encoder #(
  parameter int CMD_DEPTH = pocsag_pkg::CMD_DEPTH_DEF,
  parameter int OUT_DEPTH = pocsag_pkg::OUT_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_push,
  output logic                             in_full,
  input  pocsag_pkg::in_item_t             in_item,
  input  logic                             out_pop,
  output logic                             out_empty,
  output pocsag_pkg::out_item_t            out_item,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [pocsag_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                      cfg_data
);

  import pocsag_pkg::*;

  cmd_t      cmd_wdata, cmd_rdata;
  logic      cmd_push, cmd_full, cmd_pop, cmd_empty;
  out_item_t back_wdata;
  logic      back_push, back_full;
  cfg_wr_t   cfg;

  // Registers accept writes at any time
  assign cfg_ready = 1'b1;
  assign cfg       = '{valid: cfg_valid, index: cfg_index, data: cfg_data};

  pocsag_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_item   (in_item),
    .in_full   (in_full),
    .cmd_push  (cmd_push),
    .cmd_wdata (cmd_wdata),
    .cmd_full  (cmd_full)
  );

  pocsag_fifo #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (cmd_push),
    .wdata (cmd_wdata),
    .full  (cmd_full),
    .pop   (cmd_pop),
    .rdata (cmd_rdata),
    .empty (cmd_empty)
  );

  pocsag_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .cmd_rdata (cmd_rdata),
    .cmd_empty (cmd_empty),
    .cmd_pop   (cmd_pop),
    .out_push  (back_push),
    .out_wdata (back_wdata),
    .out_full  (back_full)
  );

  pocsag_fifo #(
    .WIDTH ($bits(out_item_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (back_push),
    .wdata (back_wdata),
    .full  (back_full),
    .pop   (out_pop),
    .rdata (out_item),
    .empty (out_empty)
  );

endmodule
